/* rtl/grid_constraint_propagator_assert.svh */
// Assertion macros shared by the grid constraint propagator modules.
// Users must have clk and rst_n in scope; no other dependencies.
`ifndef GRID_CONSTRAINT_PROPAGATOR_ASSERT_SVH
`define GRID_CONSTRAINT_PROPAGATOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define GCP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GCP_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define GCP_ASSERT(lbl, prop, msg)
`define GCP_NEVER(lbl, cond, msg)
`endif
`endif

/* rtl/gcp_pkg.sv */
// Types and constants of the grid constraint propagator.
// No dependencies.
package gcp_pkg;

    localparam int MAX_TILES = 16;
    localparam int MASK_W = 16;
    localparam int CNT_W = 13;
    localparam logic [CNT_W-1:0] CNT_MAX = 13'd4096;

    typedef enum logic [1:0] {
        CMD_LOAD     = 2'd0,
        CMD_FILL     = 2'd1,
        CMD_COLLAPSE = 2'd2,
        CMD_READ     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_RIGHT = 2'd3
    } dir_t;

    typedef enum logic [1:0] {
        CFG_GRID_WIDTH  = 2'd0,
        CFG_GRID_HEIGHT = 2'd1,
        CFG_TILE_SET    = 2'd2,
        CFG_NONE        = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_COLLAPSE_RD,
        ST_COLLAPSE_WR,
        ST_SCAN_RD,
        ST_SCAN_CK,
        ST_SRC,
        ST_NB,
        ST_UPD,
        ST_FINAL_RD,
        ST_FINAL_WR,
        ST_RESULT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_SWEEP,
        OP_COLLAPSE_RD,
        OP_COLLAPSE_WR,
        OP_SCAN_RD,
        OP_SCAN_CK,
        OP_SRC,
        OP_NB,
        OP_UPD,
        OP_FINAL_RD,
        OP_FINAL_WR,
        OP_RESULT
    } op_t;

    typedef struct packed {
        cmd_t in_cmd;
        logic in_inside;
        logic cap_inside;
        logic sweep_last;
        logic scan_end;
        logic pend_hit;
        logic nb_ok;
        logic dir_last;
    } status_t;

endpackage

/* rtl/gcp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gcp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/gcp_ctrl.sv */
// Controller state machine of the grid constraint propagator.
// Depends on gcp_pkg and grid_constraint_propagator_assert.svh.
`include "grid_constraint_propagator_assert.svh"
module gcp_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  gcp_pkg::status_t st,
    output gcp_pkg::op_t     op
);

    gcp_pkg::state_t state_reg, state_next;
    logic boot_reg, boot_next;
    logic out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gcp_pkg::ST_SWEEP;
            boot_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            boot_reg      <= boot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        boot_next      = boot_reg;
        out_valid_next = out_valid_reg && !out_ready;
        op             = gcp_pkg::OP_NONE;
        case (state_reg)
            gcp_pkg::ST_SWEEP:
            begin
                op = gcp_pkg::OP_SWEEP;
                if (st.sweep_last)
                begin
                    boot_next = 1'b0;
                    if (boot_reg)
                        state_next = gcp_pkg::ST_IDLE;
                    else if (st.cap_inside)
                        state_next = gcp_pkg::ST_FINAL_RD;
                    else
                        state_next = gcp_pkg::ST_RESULT;
                end
            end
            gcp_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    op = gcp_pkg::OP_ACCEPT;
                    case (st.in_cmd)
                        gcp_pkg::CMD_LOAD:
                            state_next = gcp_pkg::ST_RESULT;
                        gcp_pkg::CMD_FILL:
                            state_next = gcp_pkg::ST_SWEEP;
                        gcp_pkg::CMD_COLLAPSE:
                            state_next = st.in_inside ? gcp_pkg::ST_COLLAPSE_RD
                                                      : gcp_pkg::ST_RESULT;
                        default:
                            state_next = st.in_inside ? gcp_pkg::ST_FINAL_RD
                                                      : gcp_pkg::ST_RESULT;
                    endcase
                end
            end
            gcp_pkg::ST_COLLAPSE_RD:
            begin
                op         = gcp_pkg::OP_COLLAPSE_RD;
                state_next = gcp_pkg::ST_COLLAPSE_WR;
            end
            gcp_pkg::ST_COLLAPSE_WR:
            begin
                op         = gcp_pkg::OP_COLLAPSE_WR;
                state_next = gcp_pkg::ST_SCAN_RD;
            end
            gcp_pkg::ST_SCAN_RD:
            begin
                if (st.scan_end)
                    state_next = gcp_pkg::ST_FINAL_RD;
                else
                begin
                    op         = gcp_pkg::OP_SCAN_RD;
                    state_next = gcp_pkg::ST_SCAN_CK;
                end
            end
            gcp_pkg::ST_SCAN_CK:
            begin
                op         = gcp_pkg::OP_SCAN_CK;
                state_next = st.pend_hit ? gcp_pkg::ST_SRC : gcp_pkg::ST_SCAN_RD;
            end
            gcp_pkg::ST_SRC:
            begin
                op         = gcp_pkg::OP_SRC;
                state_next = gcp_pkg::ST_NB;
            end
            gcp_pkg::ST_NB:
            begin
                op = gcp_pkg::OP_NB;
                if (st.nb_ok)
                    state_next = gcp_pkg::ST_UPD;
                else if (st.dir_last)
                    state_next = gcp_pkg::ST_SCAN_RD;
            end
            gcp_pkg::ST_UPD:
            begin
                op         = gcp_pkg::OP_UPD;
                state_next = st.dir_last ? gcp_pkg::ST_SCAN_RD : gcp_pkg::ST_NB;
            end
            gcp_pkg::ST_FINAL_RD:
            begin
                op         = gcp_pkg::OP_FINAL_RD;
                state_next = gcp_pkg::ST_FINAL_WR;
            end
            gcp_pkg::ST_FINAL_WR:
            begin
                op         = gcp_pkg::OP_FINAL_WR;
                state_next = gcp_pkg::ST_RESULT;
            end
            gcp_pkg::ST_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    op             = gcp_pkg::OP_RESULT;
                    out_valid_next = 1'b1;
                    state_next     = gcp_pkg::ST_IDLE;
                end
            end
            default:
                state_next = gcp_pkg::ST_IDLE;
        endcase
    end

    assign in_ready  = (state_reg == gcp_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

    `GCP_ASSERT(a_load_to_result, (state_reg == gcp_pkg::ST_IDLE && in_valid && st.in_cmd == gcp_pkg::CMD_LOAD) |=> state_reg == gcp_pkg::ST_RESULT, "rule load did not go to result")
    `GCP_ASSERT(a_valid_from_result, $rose(out_valid_reg) |-> $past(state_reg) == gcp_pkg::ST_RESULT, "result raised outside result state")
    `GCP_ASSERT(a_result_waits, (state_reg == gcp_pkg::ST_RESULT && out_valid_reg && !out_ready) |=> state_reg == gcp_pkg::ST_RESULT, "result overwritten while stalled")

endmodule

/* rtl/gcp_datapath.sv */
// Datapath of the grid constraint propagator: registers, rule table, cell
// and pending memories. Depends on gcp_pkg, gcp_ram and the assertion header.
`include "grid_constraint_propagator_assert.svh"
module gcp_datapath #(
    parameter int GRID_W = 16,
    parameter int GRID_H = 16,
    parameter int NUM_TILES = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  gcp_pkg::op_t                    op,
    output gcp_pkg::status_t                st,
    input  logic [1:0]                      cmd,
    input  logic [3:0]                      cell_x,
    input  logic [3:0]                      cell_y,
    input  logic [3:0]                      tile,
    input  logic [1:0]                      direction,
    input  logic [gcp_pkg::MASK_W-1:0]      allowed_mask,
    input  logic                            cfg_valid,
    input  logic [1:0]                      cfg_index,
    input  logic [15:0]                     cfg_data,
    output logic [gcp_pkg::MASK_W-1:0]      cell_mask,
    output logic [gcp_pkg::CNT_W-1:0]       changed_cells
);

    localparam int CELL_N = GRID_W * GRID_H;
    localparam int AW = CELL_N > 1 ? $clog2(CELL_N) : 1;
    localparam int XW = $clog2(GRID_W + 1);
    localparam int YW = $clog2(GRID_H + 1);
    localparam int USABLE = NUM_TILES < gcp_pkg::MAX_TILES ? NUM_TILES : gcp_pkg::MAX_TILES;
    localparam logic [gcp_pkg::MASK_W-1:0] LIM = gcp_pkg::MASK_W'((33'd1 << USABLE) - 33'd1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(CELL_N - 1);

    logic [4:0]  grid_width_reg, grid_height_reg;
    logic [15:0] tile_set_reg;
    logic [gcp_pkg::MASK_W-1:0] rule_reg [4][gcp_pkg::MAX_TILES];

    logic [XW-1:0] w_act, cap_x_reg, cur_x_reg, ptr_x_reg, res_x_reg, nb_x, succ_x;
    logic [YW-1:0] h_act, cap_y_reg, cur_y_reg, ptr_y_reg, res_y_reg, nb_y, succ_y;
    logic [3:0] cap_tile_reg;
    logic cap_inside_reg, up_added_reg, in_inside, nb_ok;
    gcp_pkg::dir_t dir_reg;
    logic [gcp_pkg::MASK_W-1:0] src_reg, fill_val_reg, res_mask_reg, allow, upd;
    logic [gcp_pkg::MASK_W-1:0] out_mask_reg;
    logic [gcp_pkg::CNT_W-1:0] cnt_reg, out_cnt_reg;
    logic [AW-1:0] sweep_reg;

    logic cell_we, pend_we;
    logic [AW-1:0] cell_waddr, cell_raddr, pend_waddr, pend_raddr;
    logic [gcp_pkg::MASK_W-1:0] cell_wdata, cell_rdata;
    logic [0:0] pend_wdata, pend_rdata;
    logic nb_changed;

    function automatic logic [AW-1:0] addr_of(input logic [XW-1:0] x, input logic [YW-1:0] y);
        return AW'(32'(y) * GRID_W + 32'(x));
    endfunction

    always_comb
    begin
        if (grid_width_reg == 5'd0)
            w_act = XW'(1);
        else if (32'(grid_width_reg) > GRID_W)
            w_act = XW'(GRID_W);
        else
            w_act = XW'(grid_width_reg);
        if (grid_height_reg == 5'd0)
            h_act = YW'(1);
        else if (32'(grid_height_reg) > GRID_H)
            h_act = YW'(GRID_H);
        else
            h_act = YW'(grid_height_reg);
    end

    assign in_inside = (32'(cell_x) < 32'(w_act)) && (32'(cell_y) < 32'(h_act));

    always_comb
    begin
        if (32'(ptr_x_reg) + 32'd1 < 32'(w_act))
        begin
            succ_x = ptr_x_reg + XW'(1);
            succ_y = ptr_y_reg;
        end
        else
        begin
            succ_x = '0;
            succ_y = ptr_y_reg + YW'(1);
        end
    end

    always_comb
    begin
        nb_x  = cur_x_reg;
        nb_y  = cur_y_reg;
        nb_ok = 1'b0;
        case (dir_reg)
            gcp_pkg::DIR_UP:
            begin
                nb_ok = (cur_y_reg != '0);
                nb_y  = cur_y_reg - YW'(1);
            end
            gcp_pkg::DIR_DOWN:
            begin
                nb_ok = (32'(cur_y_reg) + 32'd1 < 32'(h_act));
                nb_y  = cur_y_reg + YW'(1);
            end
            gcp_pkg::DIR_LEFT:
            begin
                nb_ok = (cur_x_reg != '0);
                nb_x  = cur_x_reg - XW'(1);
            end
            default:
            begin
                nb_ok = (32'(cur_x_reg) + 32'd1 < 32'(w_act));
                nb_x  = cur_x_reg + XW'(1);
            end
        endcase
    end

    always_comb
    begin
        allow = '0;
        for (int n = 0; n < gcp_pkg::MAX_TILES; n++)
        begin
            if (src_reg[n])
                allow = allow | rule_reg[dir_reg][n];
        end
    end

    assign upd        = cell_rdata & allow;
    assign nb_changed = (upd != cell_rdata);

    always_comb
    begin
        cell_we    = 1'b0;
        cell_waddr = addr_of(cap_x_reg, cap_y_reg);
        cell_wdata = cell_rdata & (gcp_pkg::MASK_W'(1) << cap_tile_reg) & LIM;
        cell_raddr = addr_of(cap_x_reg, cap_y_reg);
        pend_we    = 1'b0;
        pend_waddr = addr_of(cap_x_reg, cap_y_reg);
        pend_wdata = 1'b1;
        pend_raddr = addr_of(ptr_x_reg, ptr_y_reg);
        case (op)
            gcp_pkg::OP_SWEEP:
            begin
                cell_we    = 1'b1;
                cell_waddr = sweep_reg;
                cell_wdata = fill_val_reg;
                pend_we    = 1'b1;
                pend_waddr = sweep_reg;
                pend_wdata = 1'b0;
            end
            gcp_pkg::OP_COLLAPSE_WR:
            begin
                cell_we = 1'b1;
                pend_we = 1'b1;
            end
            gcp_pkg::OP_SCAN_CK:
            begin
                cell_raddr = addr_of(ptr_x_reg, ptr_y_reg);
                pend_we    = pend_rdata[0];
                pend_waddr = addr_of(ptr_x_reg, ptr_y_reg);
                pend_wdata = 1'b0;
            end
            gcp_pkg::OP_NB:
                cell_raddr = addr_of(nb_x, nb_y);
            gcp_pkg::OP_UPD:
            begin
                cell_we    = nb_changed;
                cell_waddr = addr_of(nb_x, nb_y);
                cell_wdata = upd;
                pend_we    = nb_changed;
                pend_waddr = addr_of(nb_x, nb_y);
            end
            default:
            begin
                cell_we = 1'b0;
            end
        endcase
    end

    gcp_ram #(.WIDTH(gcp_pkg::MASK_W), .DEPTH(CELL_N)) u_cell_ram (
        .clk   (clk),
        .we    (cell_we),
        .waddr (cell_waddr),
        .wdata (cell_wdata),
        .raddr (cell_raddr),
        .rdata (cell_rdata)
    );

    gcp_ram #(.WIDTH(1), .DEPTH(CELL_N)) u_pend_ram (
        .clk   (clk),
        .we    (pend_we),
        .waddr (pend_waddr),
        .wdata (pend_wdata),
        .raddr (pend_raddr),
        .rdata (pend_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= 5'd16;
            grid_height_reg <= 5'd16;
            tile_set_reg    <= 16'hFFFF;
            for (int d = 0; d < 4; d++)
                for (int n = 0; n < gcp_pkg::MAX_TILES; n++)
                    rule_reg[d][n] <= '0;
            sweep_reg      <= '0;
            fill_val_reg   <= LIM;
            cap_inside_reg <= 1'b0;
            cnt_reg        <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (gcp_pkg::cfg_idx_t'(cfg_index))
                    gcp_pkg::CFG_GRID_WIDTH:  grid_width_reg  <= cfg_data[4:0];
                    gcp_pkg::CFG_GRID_HEIGHT: grid_height_reg <= cfg_data[4:0];
                    gcp_pkg::CFG_TILE_SET:    tile_set_reg    <= cfg_data;
                    default:                  tile_set_reg    <= tile_set_reg;
                endcase
            end
            if (op == gcp_pkg::OP_SWEEP)
                sweep_reg <= (sweep_reg == LAST_ADDR) ? '0 : sweep_reg + AW'(1);
            if (op == gcp_pkg::OP_ACCEPT)
            begin
                cap_inside_reg <= in_inside;
                cnt_reg        <= '0;
                fill_val_reg   <= tile_set_reg & LIM;
                if (gcp_pkg::cmd_t'(cmd) == gcp_pkg::CMD_LOAD && 32'(tile) < USABLE)
                    rule_reg[direction][tile] <= allowed_mask & LIM;
            end
            if (op == gcp_pkg::OP_UPD && nb_changed && cnt_reg < gcp_pkg::CNT_MAX)
                cnt_reg <= cnt_reg + gcp_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        case (op)
            gcp_pkg::OP_ACCEPT:
            begin
                cap_x_reg    <= XW'(32'(cell_x));
                cap_y_reg    <= YW'(32'(cell_y));
                cap_tile_reg <= tile;
                res_mask_reg <= '0;
            end
            gcp_pkg::OP_COLLAPSE_WR:
            begin
                ptr_x_reg <= cap_x_reg;
                ptr_y_reg <= cap_y_reg;
            end
            gcp_pkg::OP_SCAN_CK:
            begin
                if (pend_rdata[0])
                begin
                    cur_x_reg    <= ptr_x_reg;
                    cur_y_reg    <= ptr_y_reg;
                    res_x_reg    <= succ_x;
                    res_y_reg    <= succ_y;
                    up_added_reg <= 1'b0;
                    dir_reg      <= gcp_pkg::DIR_UP;
                end
                else
                begin
                    ptr_x_reg <= succ_x;
                    ptr_y_reg <= succ_y;
                end
            end
            gcp_pkg::OP_SRC:
                src_reg <= cell_rdata;
            gcp_pkg::OP_NB:
            begin
                if (!nb_ok)
                begin
                    if (dir_reg == gcp_pkg::DIR_RIGHT)
                    begin
                        ptr_x_reg <= res_x_reg;
                        ptr_y_reg <= res_y_reg;
                    end
                    else
                        dir_reg <= gcp_pkg::dir_t'(2'(dir_reg) + 2'd1);
                end
            end
            gcp_pkg::OP_UPD:
            begin
                if (nb_changed && dir_reg == gcp_pkg::DIR_UP)
                begin
                    res_x_reg    <= nb_x;
                    res_y_reg    <= nb_y;
                    up_added_reg <= 1'b1;
                end
                if (nb_changed && dir_reg == gcp_pkg::DIR_LEFT && !up_added_reg)
                begin
                    res_x_reg <= nb_x;
                    res_y_reg <= nb_y;
                end
                if (dir_reg == gcp_pkg::DIR_RIGHT)
                begin
                    ptr_x_reg <= res_x_reg;
                    ptr_y_reg <= res_y_reg;
                end
                else
                    dir_reg <= gcp_pkg::dir_t'(2'(dir_reg) + 2'd1);
            end
            gcp_pkg::OP_FINAL_WR:
                res_mask_reg <= cell_rdata;
            gcp_pkg::OP_RESULT:
            begin
                out_mask_reg <= res_mask_reg;
                out_cnt_reg  <= cnt_reg;
            end
            default:
            begin
                src_reg <= src_reg;
            end
        endcase
    end

    assign cell_mask     = out_mask_reg;
    assign changed_cells = out_cnt_reg;

    assign st.in_cmd     = gcp_pkg::cmd_t'(cmd);
    assign st.in_inside  = in_inside;
    assign st.cap_inside = cap_inside_reg;
    assign st.sweep_last = (sweep_reg == LAST_ADDR);
    assign st.scan_end   = (ptr_y_reg == h_act);
    assign st.pend_hit   = pend_rdata[0];
    assign st.nb_ok      = nb_ok;
    assign st.dir_last   = (dir_reg == gcp_pkg::DIR_RIGHT);

    `GCP_NEVER(a_count_saturates, cnt_reg > gcp_pkg::CNT_MAX, "change count above saturation")

endmodule

/* rtl/grid_constraint_propagator.sv */
// Top level of the grid constraint propagator: controller and datapath.
// Depends on gcp_pkg, gcp_ctrl, gcp_datapath and gcp_ram.
//
//   Channel  Handshake            Payload
//   in       in_valid/in_ready    cmd, cell_x, cell_y, tile, direction, allowed_mask
//   out      out_valid/out_ready  cell_mask, changed_cells
//   cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A rule load goes straight to the result, a read passes through the final read and write
// states, and a fill first sweeps every cell. A collapse scans the cells for pending marks
// and takes each pending cell through the source, neighbour and update states, bound by the
// single read port of the cell memory. After reset a clearing pass over all GRID_W*GRID_H
// cells runs before the first request is taken; configuration writes are accepted throughout.
// A stalled result holds in the output register while the next request is taken.
module grid_constraint_propagator #(
    parameter int GRID_W = 16,
    parameter int GRID_H = 16,
    parameter int NUM_TILES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [3:0]  cell_x,
    input  logic [3:0]  cell_y,
    input  logic [3:0]  tile,
    input  logic [1:0]  direction,
    input  logic [15:0] allowed_mask,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] cell_mask,
    output logic [12:0] changed_cells,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    gcp_pkg::status_t st;
    gcp_pkg::op_t     op;

    assign cfg_ready = 1'b1;

    gcp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .st        (st),
        .op        (op)
    );

    gcp_datapath #(
        .GRID_W    (GRID_W),
        .GRID_H    (GRID_H),
        .NUM_TILES (NUM_TILES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .op            (op),
        .st            (st),
        .cmd           (cmd),
        .cell_x        (cell_x),
        .cell_y        (cell_y),
        .tile          (tile),
        .direction     (direction),
        .allowed_mask  (allowed_mask),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cell_mask     (cell_mask),
        .changed_cells (changed_cells)
    );

endmodule
